@@ rtl/dcpt_pkg.sv @@
// Package for the dual-chamber pacing timer: widths, interval and register codes,
// payload and state structs, and the saturating add and limit compare helpers.
// Depends on nothing; every other file in rtl/ imports it.
`default_nettype none

package dcpt_pkg;

    // Width of each interval timer; the timers saturate at 2^TIMER_BITS - 1.
    localparam int TIMER_BITS = 16;
    // Width of a limit register and of the configuration data.
    localparam int LIMIT_W    = 16;
    // Width used when a timer is compared with a limit.
    localparam int CMP_W      = (TIMER_BITS > LIMIT_W) ? TIMER_BITS : LIMIT_W;
    localparam int ELAPSED_W  = 8;
    localparam int IV_COUNT   = 6;
    localparam int CFG_IDX_W  = 3;

    // Interval positions within the timer and running vectors.
    localparam int IV_LRI   = 0;
    localparam int IV_URI   = 1;
    localparam int IV_PVARP = 2;
    localparam int IV_VRP   = 3;
    localparam int IV_AVI   = 4;
    localparam int IV_AEI   = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LRI   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_URI   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PVARP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VRP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AVI   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AEI   = 3'd5;

    // Reset values of the limit registers, in milliseconds.
    localparam logic [LIMIT_W-1:0] LRI_RESET   = 16'd950;
    localparam logic [LIMIT_W-1:0] URI_RESET   = 16'd900;
    localparam logic [LIMIT_W-1:0] PVARP_RESET = 16'd50;
    localparam logic [LIMIT_W-1:0] VRP_RESET   = 16'd150;
    localparam logic [LIMIT_W-1:0] AVI_RESET   = 16'd300;
    localparam logic [LIMIT_W-1:0] AEI_RESET   = 16'd800;

    typedef struct packed {
        logic [ELAPSED_W-1:0] elapsed_ms;
        logic                 atrial_sense;
        logic                 ventricular_sense;
    } t_in_word;

    typedef struct packed {
        logic atrial_pace;
        logic ventricular_pace;
        logic uri_active;
        logic pvarp_active;
        logic vrp_active;
    } t_out_word;

    typedef struct packed {
        logic [LIMIT_W-1:0] lri;
        logic [LIMIT_W-1:0] uri;
        logic [LIMIT_W-1:0] pvarp;
        logic [LIMIT_W-1:0] vrp;
        logic [LIMIT_W-1:0] avi;
        logic [LIMIT_W-1:0] aei;
    } t_limits;

    // State kept from one word to the next.
    typedef struct packed {
        logic [IV_COUNT-1:0][TIMER_BITS-1:0] timers;
        logic [IV_COUNT-1:0]                 running;
        logic                                uri_flag;
        logic                                pvarp_flag;
        logic                                vrp_flag;
    } t_pace_state;

    // State plus the pace bits raised so far within the current word.
    typedef struct packed {
        t_pace_state st;
        logic        ap;
        logic        vp;
    } t_pass;

    // Timer plus elapsed time, held at the top value instead of wrapping.
    function automatic logic [TIMER_BITS-1:0] sat_add(
        input logic [TIMER_BITS-1:0] timer,
        input logic [ELAPSED_W-1:0]  elapsed
    );
        logic [TIMER_BITS:0] sum;
        sum = {1'b0, timer} + (TIMER_BITS + 1)'(elapsed);
        return sum[TIMER_BITS] ? {TIMER_BITS{1'b1}} : sum[TIMER_BITS-1:0];
    endfunction

    // True when the timer has reached the limit.
    function automatic logic reached(
        input logic [TIMER_BITS-1:0] timer,
        input logic [LIMIT_W-1:0]    limit
    );
        return CMP_W'(timer) >= CMP_W'(limit);
    endfunction

endpackage

`default_nettype wire

@@ rtl/dcpt_cfg_regs.sv @@
// Limit registers of the pacing timer, written through the configuration port.
// Depends on dcpt_pkg for the register indexes, reset values and the limits struct.
`default_nettype none

module dcpt_cfg_regs import dcpt_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_wr_index,
    input  wire logic [LIMIT_W-1:0]   i_wr_data,
    output t_limits                   o_limits
);

    t_limits r_limits;
    t_limits n_limits;

    always_comb begin
        n_limits = r_limits;
        if (i_wr_en) begin
            unique case (i_wr_index)
                REG_LRI:   n_limits.lri   = i_wr_data;
                REG_URI:   n_limits.uri   = i_wr_data;
                REG_PVARP: n_limits.pvarp = i_wr_data;
                REG_VRP:   n_limits.vrp   = i_wr_data;
                REG_AVI:   n_limits.avi   = i_wr_data;
                REG_AEI:   n_limits.aei   = i_wr_data;
                default:   n_limits = r_limits;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.lri   <= LRI_RESET;
            r_limits.uri   <= URI_RESET;
            r_limits.pvarp <= PVARP_RESET;
            r_limits.vrp   <= VRP_RESET;
            r_limits.avi   <= AVI_RESET;
            r_limits.aei   <= AEI_RESET;
        end else begin
            r_limits <= n_limits;
        end
    end

    assign o_limits = r_limits;

endmodule

`default_nettype wire

@@ rtl/dcpt_eval_pass.sv @@
// One evaluation pass over the six intervals in LRI, URI, PVARP, VRP, AVI, AEI order.
// Purely combinational; depends on dcpt_pkg for the state structs and compare helper.
`default_nettype none

module dcpt_eval_pass import dcpt_pkg::*; (
    input  wire t_limits i_limits,
    input  wire logic    i_as,
    input  wire logic    i_vs,
    input  wire t_pass   i_pass,
    output t_pass        o_pass
);

    typedef struct packed {
        logic [TIMER_BITS-1:0] timer;
        logic                  run;
        logic                  flag;
    } t_refr;

    // Shared rule of the three refractory-style intervals.
    function automatic t_refr step_refr(
        input t_refr              cur,
        input logic               vev,
        input logic [LIMIT_W-1:0] limit
    );
        t_refr nxt;
        nxt = cur;
        if (!cur.run) begin
            if (vev) begin
                nxt.timer = '0;
                nxt.run   = 1'b1;
            end
        end else if (!reached(cur.timer, limit)) begin
            nxt.flag = 1'b1;
        end else begin
            nxt.flag = 1'b0;
            nxt.run  = 1'b0;
        end
        return nxt;
    endfunction

    t_refr w_uri;
    t_refr w_pvarp;
    t_refr w_vrp;
    logic  w_vev;

    always_comb begin
        o_pass = i_pass;

        // Lower rate interval: restarted by any ventricular event, paces on expiry.
        if (!o_pass.st.running[IV_LRI]) begin
            if (i_vs || o_pass.vp) begin
                o_pass.st.running[IV_LRI] = 1'b1;
                o_pass.st.timers[IV_LRI]  = '0;
            end
        end else begin
            if (i_vs || o_pass.vp) begin
                o_pass.st.timers[IV_LRI] = '0;
            end
            if (reached(o_pass.st.timers[IV_LRI], i_limits.lri)) begin
                o_pass.vp                = 1'b1;
                o_pass.st.timers[IV_LRI] = '0;
            end
        end

        w_vev = i_vs || o_pass.vp;

        w_uri = step_refr({o_pass.st.timers[IV_URI], o_pass.st.running[IV_URI],
                           o_pass.st.uri_flag}, w_vev, i_limits.uri);
        o_pass.st.timers[IV_URI]  = w_uri.timer;
        o_pass.st.running[IV_URI] = w_uri.run;
        o_pass.st.uri_flag        = w_uri.flag;

        w_pvarp = step_refr({o_pass.st.timers[IV_PVARP], o_pass.st.running[IV_PVARP],
                             o_pass.st.pvarp_flag}, w_vev, i_limits.pvarp);
        o_pass.st.timers[IV_PVARP]  = w_pvarp.timer;
        o_pass.st.running[IV_PVARP] = w_pvarp.run;
        o_pass.st.pvarp_flag        = w_pvarp.flag;

        w_vrp = step_refr({o_pass.st.timers[IV_VRP], o_pass.st.running[IV_VRP],
                           o_pass.st.vrp_flag}, w_vev, i_limits.vrp);
        o_pass.st.timers[IV_VRP]  = w_vrp.timer;
        o_pass.st.running[IV_VRP] = w_vrp.run;
        o_pass.st.vrp_flag        = w_vrp.flag;

        // Atrioventricular interval, gated by the atrial refractory and upper rate flags.
        if (!o_pass.st.running[IV_AVI]) begin
            if ((i_as || o_pass.ap) && !o_pass.st.pvarp_flag) begin
                o_pass.st.timers[IV_AVI]  = '0;
                o_pass.st.running[IV_AVI] = 1'b1;
            end
        end else if (i_vs) begin
            o_pass.st.running[IV_AVI] = 1'b0;
        end else if (reached(o_pass.st.timers[IV_AVI], i_limits.avi)
                     && !o_pass.st.uri_flag) begin
            o_pass.vp                 = 1'b1;
            o_pass.st.running[IV_AVI] = 1'b0;
        end

        // Atrial escape interval, gated by the ventricular refractory flag.
        if (!o_pass.st.running[IV_AEI]) begin
            if ((i_vs || o_pass.vp) && !o_pass.st.vrp_flag) begin
                o_pass.st.timers[IV_AEI]  = '0;
                o_pass.st.running[IV_AEI] = 1'b1;
            end
        end else if (i_as) begin
            o_pass.st.running[IV_AEI] = 1'b0;
        end else if (reached(o_pass.st.timers[IV_AEI], i_limits.aei)) begin
            o_pass.ap                 = 1'b1;
            o_pass.st.running[IV_AEI] = 1'b0;
        end
    end

endmodule

`default_nettype wire

@@ rtl/dcpt_core.sv @@
// Timer state of the pacing timer: advances the timers, runs two evaluation passes
// and stores the new state on each accepted word. Depends on dcpt_pkg, dcpt_eval_pass.
`default_nettype none

module dcpt_core import dcpt_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_accept,
    input  wire t_in_word i_word,
    input  wire t_limits i_limits,
    output t_out_word    o_result
);

    t_pace_state r_state;
    t_pace_state n_state;
    t_pass       w_start;
    t_pass       w_mid;
    t_pass       w_end;

    // Every timer counts, whether its interval is running or not.
    always_comb begin
        w_start    = '0;
        w_start.st = r_state;
        for (int k = 0; k < IV_COUNT; k++) begin
            w_start.st.timers[k] = sat_add(r_state.timers[k], i_word.elapsed_ms);
        end
    end

    dcpt_eval_pass u_pass_a (
        .i_limits (i_limits),
        .i_as     (i_word.atrial_sense),
        .i_vs     (i_word.ventricular_sense),
        .i_pass   (w_start),
        .o_pass   (w_mid)
    );

    dcpt_eval_pass u_pass_b (
        .i_limits (i_limits),
        .i_as     (i_word.atrial_sense),
        .i_vs     (i_word.ventricular_sense),
        .i_pass   (w_mid),
        .o_pass   (w_end)
    );

    assign n_state = i_accept ? w_end.st : r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_result.atrial_pace      = w_end.ap;
    assign o_result.ventricular_pace = w_end.vp;
    assign o_result.uri_active       = w_end.st.uri_flag;
    assign o_result.pvarp_active     = w_end.st.pvarp_flag;
    assign o_result.vrp_active       = w_end.st.vrp_flag;

endmodule

`default_nettype wire

@@ rtl/dual_chamber_pacing_timer_top.sv @@
// Top level of the dual-chamber pacing timer: handshakes, output register and wiring.
// Depends on dcpt_pkg, dcpt_cfg_regs and dcpt_core.
//
//   Channel  Direction  Handshake                  Word
//   in       to block   i_in_valid / o_in_ready    i_in_word  (t_in_word)
//   out      from block o_out_valid / i_out_ready  o_out_word (t_out_word)
//   cfg      to block   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Each input word is worked through in the cycle it is accepted: the six timers are
// advanced, both evaluation passes run, and the new state and the result word are
// stored at the same clock edge, so one word per cycle is sustained.
// The only stall comes from the output register: a new word is taken whenever that
// register is empty or is being emptied in the same cycle.
// Reset is synchronous and active low; it clears the timers, flags and output valid,
// and loads the limit registers with their default values.
`default_nettype none

module dual_chamber_pacing_timer_top import dcpt_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_word             i_in_word,

    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_word                 o_out_word,

    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [LIMIT_W-1:0]   i_cfg_data
);

    t_limits   w_limits;
    t_out_word w_result;
    logic      w_in_accept;
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_word r_out_word;

    // Limit registers can always take a write.
    assign o_cfg_ready = 1'b1;

    dcpt_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_limits   (w_limits)
    );

    // The input side is free whenever the output register will be empty next cycle.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_accept = i_in_valid && o_in_ready;

    dcpt_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_in_accept),
        .i_word   (i_in_word),
        .i_limits (w_limits),
        .o_result (w_result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_in_accept) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // The result word needs no reset; it is only looked at while valid is high.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_out_word <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

@@ test/pace_checker.sv @@
// Checker for the dual-chamber pacing timer: watches the three channels, predicts each
// result word from its own copy of the timers, flags and limits, and compares.
// Depends on dcpt_pkg for the word types, widths, register codes and reset limits.
module pace_checker import dcpt_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_ready,
    input  t_in_word                  i_in_word,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_ready,
    input  t_out_word                 i_out_word,
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [LIMIT_W-1:0]   i_cfg_data,
    output int                        o_fail_count,
    output int                        o_words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned TIMER_TOP = (64'd1 << TIMER_BITS) - 64'd1;

    logic [TIMER_BITS-1:0] tmr [IV_COUNT];
    bit                    run [IV_COUNT];
    logic [LIMIT_W-1:0]    lim [IV_COUNT];
    bit                    uri_f, pvarp_f, vrp_f;
    bit                    ap_now, vp_now;

    t_out_word predicted_pulses [$];
    int        fails = 0;
    int        pending = 0;

    assign o_fail_count    = fails;
    assign o_words_pending = pending;

    function automatic void clear_model();
        for (int k = 0; k < IV_COUNT; k++) begin
            tmr[k] = '0;
            run[k] = 1'b0;
        end
        lim[IV_LRI]   = LRI_RESET;
        lim[IV_URI]   = URI_RESET;
        lim[IV_PVARP] = PVARP_RESET;
        lim[IV_VRP]   = VRP_RESET;
        lim[IV_AVI]   = AVI_RESET;
        lim[IV_AEI]   = AEI_RESET;
        uri_f   = 1'b0;
        pvarp_f = 1'b0;
        vrp_f   = 1'b0;
    endfunction

    function automatic bit hit(int k);
        return 64'(tmr[k]) >= 64'(lim[k]);
    endfunction

    // URI, PVARP and VRP share one rule: a ventricular event starts the interval, the
    // flag is held while the timer is below its limit, and the interval ends at it.
    function automatic bit refractory_step(int k, bit vevent, bit flag);
        if (!run[k]) begin
            if (vevent) begin
                tmr[k] = '0;
                run[k] = 1'b1;
            end
            return flag;
        end
        if (!hit(k))
            return 1'b1;
        run[k] = 1'b0;
        return 1'b0;
    endfunction

    function automatic void eval_pass(bit as, bit vs);
        if (!run[IV_LRI]) begin
            if (vs || vp_now) begin
                run[IV_LRI] = 1'b1;
                tmr[IV_LRI] = '0;
            end
        end else begin
            if (vs || vp_now)
                tmr[IV_LRI] = '0;
            if (hit(IV_LRI)) begin
                vp_now      = 1'b1;
                tmr[IV_LRI] = '0;
            end
        end

        uri_f   = refractory_step(IV_URI, vs || vp_now, uri_f);
        pvarp_f = refractory_step(IV_PVARP, vs || vp_now, pvarp_f);
        vrp_f   = refractory_step(IV_VRP, vs || vp_now, vrp_f);

        if (!run[IV_AVI]) begin
            if ((as || ap_now) && !pvarp_f) begin
                tmr[IV_AVI] = '0;
                run[IV_AVI] = 1'b1;
            end
        end else if (vs) begin
            run[IV_AVI] = 1'b0;
        end else if (hit(IV_AVI) && !uri_f) begin
            vp_now      = 1'b1;
            run[IV_AVI] = 1'b0;
        end

        if (!run[IV_AEI]) begin
            if ((vs || vp_now) && !vrp_f) begin
                tmr[IV_AEI] = '0;
                run[IV_AEI] = 1'b1;
            end
        end else if (as) begin
            run[IV_AEI] = 1'b0;
        end else if (hit(IV_AEI)) begin
            ap_now      = 1'b1;
            run[IV_AEI] = 1'b0;
        end
    endfunction

    // Advances every timer, saturating, then runs the evaluation twice.
    function automatic t_out_word predict_pulses(t_in_word w);
        longint unsigned sum;
        t_out_word       res;
        for (int k = 0; k < IV_COUNT; k++) begin
            sum    = 64'(tmr[k]) + 64'(w.elapsed_ms);
            tmr[k] = (sum > TIMER_TOP) ? TIMER_BITS'(TIMER_TOP) : TIMER_BITS'(sum);
        end
        ap_now = 1'b0;
        vp_now = 1'b0;
        eval_pass(w.atrial_sense, w.ventricular_sense);
        eval_pass(w.atrial_sense, w.ventricular_sense);
        res.atrial_pace      = ap_now;
        res.ventricular_pace = vp_now;
        res.uri_active       = uri_f;
        res.pvarp_active     = pvarp_f;
        res.vrp_active       = vrp_f;
        return res;
    endfunction

    function automatic void compare_field(string name, logic want, logic got);
        if (got !== want) begin
            $display("%0t: %s expected %b actual %b", $realtime, name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            clear_model();
            predicted_pulses.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (predicted_pulses.size() == 0) begin
                    $display("%0t: result word %b arrived with nothing expected",
                             $realtime, i_out_word);
                    fails++;
                end else begin
                    want = predicted_pulses.pop_front();
                    compare_field("atrial_pace", want.atrial_pace, i_out_word.atrial_pace);
                    compare_field("ventricular_pace", want.ventricular_pace,
                                  i_out_word.ventricular_pace);
                    compare_field("uri_active", want.uri_active, i_out_word.uri_active);
                    compare_field("pvarp_active", want.pvarp_active,
                                  i_out_word.pvarp_active);
                    compare_field("vrp_active", want.vrp_active, i_out_word.vrp_active);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_LRI:   lim[IV_LRI]   = i_cfg_data;
                    REG_URI:   lim[IV_URI]   = i_cfg_data;
                    REG_PVARP: lim[IV_PVARP] = i_cfg_data;
                    REG_VRP:   lim[IV_VRP]   = i_cfg_data;
                    REG_AVI:   lim[IV_AVI]   = i_cfg_data;
                    REG_AEI:   lim[IV_AEI]   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                predicted_pulses.push_back(predict_pulses(i_in_word));
        end
        pending = predicted_pulses.size();
    end

endmodule

@@ test/testbench.sv @@
// Top of the pacing timer testbench: clock, reset, input, configuration and output
// stimulus, and the verdict. Depends on dcpt_pkg, dual_chamber_pacing_timer_top and
// pace_checker, which does all prediction and comparison.
module testbench;
    import dcpt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Indexes beyond the six limit registers; the block must ignore writes to them.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // Limit styles for a phase of the run.
    localparam int STYLE_ZERO      = 0;
    localparam int STYLE_MAX       = 1;
    localparam int STYLE_CLINICAL  = 2;
    localparam int STYLE_MIXED     = 3;

    // Receiver behaviours.
    localparam int RX_ALWAYS = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_MASK   = 3;

    // Upper bound on the length of the run, used by the watchdog below.
    localparam int CYCLE_LIMIT = 200000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_in_word             in_word = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_word            out_word;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LIMIT_W-1:0]   cfg_data = '0;

    int fails;
    int words_pending;
    int burst_left = 0;
    int cycles = 0;

    dual_chamber_pacing_timer_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    pace_checker u_pace_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_in_word       (in_word),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_out_word      (out_word),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fails),
        .o_words_pending (words_pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: if the run has not ended by the limit, something has hung.
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    // The receiver picks a new behaviour for each window: always ready, a coin toss,
    // mostly stalled, or a fixed rotating mask. Ready only changes on a falling edge.
    initial begin
        int   mode;
        int   window;
        logic [7:0] mask;
        window = 0;
        mode   = RX_ALWAYS;
        mask   = 8'hFF;
        forever begin
            @(negedge i_clk);
            if (window == 0) begin
                window = 40;
                mode   = $urandom_range(RX_ALWAYS, RX_MASK);
                mask   = 8'($urandom_range(1, 255));
            end
            window--;
            case (mode)
                RX_ALWAYS: out_ready <= 1'b1;
                RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                default:   out_ready <= mask[window % 8];
            endcase
        end
    end

    // Offers one word and returns at the falling edge after it has been taken. Words go
    // out in bursts; between bursts valid drops for a random gap, sometimes for none
    // at all, so that back-to-back words appear too. Valid is only lowered when a real
    // gap follows, so it is never lowered and raised within one time step.
    task automatic send_beat(input logic [ELAPSED_W-1:0] e, input logic a, input logic v);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid               <= 1'b1;
        in_word.elapsed_ms        <= e;
        in_word.atrial_sense      <= a;
        in_word.ventricular_sense <= v;
        do @(posedge i_clk); while (!in_ready);
        @(negedge i_clk);
        burst_left--;
    endtask

    // Drops valid and waits until every result word has come back, so that the
    // limits may be rewritten with the block idle. Each word yields exactly one
    // result, so nothing can still be in flight once the count reaches zero.
    task automatic settle();
        in_valid   <= 1'b0;
        burst_left = 0;
        wait (words_pending == 0);
        @(negedge i_clk);
    endtask

    // One register write; valid stays high so that writes may follow back to back.
    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
    endtask

    function automatic logic [LIMIT_W-1:0] pick_limit(int style, int lo, int hi);
        case (style)
            STYLE_ZERO:     return '0;
            STYLE_MAX:      return '1;
            STYLE_CLINICAL: return LIMIT_W'($urandom_range(lo, hi));
            default: begin
                case ($urandom_range(0, 4))
                    0:       return '0;
                    1:       return '1;
                    2:       return LIMIT_W'($urandom);
                    default: return LIMIT_W'($urandom_range(0, 1500));
                endcase
            end
        endcase
    endfunction

    // Writes all six limits, plus the two unused indexes when asked, then drops valid.
    task automatic program_limits(input int style, input bit spare);
        cfg_put(REG_LRI,   pick_limit(style, 700, 1200));
        cfg_put(REG_URI,   pick_limit(style, 400, 900));
        cfg_put(REG_PVARP, pick_limit(style, 20, 300));
        cfg_put(REG_VRP,   pick_limit(style, 50, 300));
        cfg_put(REG_AVI,   pick_limit(style, 50, 300));
        cfg_put(REG_AEI,   pick_limit(style, 300, 900));
        if (spare) begin
            cfg_put(REG_SPARE_LO, LIMIT_W'($urandom));
            cfg_put(REG_SPARE_HI, LIMIT_W'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    // A phase of random words. The first silent_first words may be a long silence at the
    // largest step, started by one ventricular sense, which drives every timer into
    // saturation. After that the elapsed time is mostly spread over its whole range
    // with some runs of small steps, and the sense rate set for the phase decides
    // whether the rhythm is mostly sensed or mostly paced.
    task automatic run_phase(input int n, input int sense_pct, input int silent_first);
        int   pick;
        logic [ELAPSED_W-1:0] e;
        for (int i = 0; i < n; i++) begin
            if (i < silent_first) begin
                send_beat('1, 1'b0, (i == 0));
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 2)
                    e = ELAPSED_W'($urandom_range(0, 15));
                else if (pick < 8)
                    e = ELAPSED_W'($urandom_range(0, 255));
                else
                    e = ELAPSED_W'($urandom_range(200, 255));
                send_beat(e, ($urandom_range(0, 99) < sense_pct),
                          ($urandom_range(0, 99) < sense_pct));
            end
        end
    endtask

    initial begin
        int styles [10];
        int rates [4];
        styles = '{STYLE_CLINICAL, STYLE_MIXED, STYLE_ZERO, STYLE_CLINICAL, STYLE_MIXED,
                   STYLE_CLINICAL, STYLE_MIXED, STYLE_CLINICAL, STYLE_MIXED, STYLE_MIXED};
        rates  = '{0, 5, 15, 30};

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed words at the reset limits: nothing at all, a large idle step, a
        // ventricular sense that starts the ventricular intervals, an atrial sense
        // inside PVARP and one after it, then silence long enough for the AV delay
        // and the lower rate interval to run out, and both senses together.
        send_beat(8'd0, 1'b0, 1'b0);
        send_beat(8'd255, 1'b0, 1'b0);
        send_beat(8'd0, 1'b0, 1'b1);
        send_beat(8'd10, 1'b1, 1'b0);
        send_beat(8'd100, 1'b1, 1'b0);
        repeat (6) send_beat(8'd255, 1'b0, 1'b0);
        send_beat(8'd0, 1'b1, 1'b1);
        send_beat(8'd255, 1'b1, 1'b1);
        send_beat(8'd1, 1'b0, 1'b0);
        send_beat(8'd254, 1'b0, 1'b1);
        send_beat(8'd128, 1'b1, 1'b0);
        send_beat(8'd127, 1'b0, 1'b0);
        send_beat(8'd255, 1'b0, 1'b0);
        settle();

        // Limits of zero: every running interval ends or expires on its first check.
        program_limits(STYLE_ZERO, 1'b1);
        send_beat(8'd0, 1'b0, 1'b0);
        send_beat(8'd0, 1'b0, 1'b1);
        send_beat(8'd0, 1'b1, 1'b0);
        send_beat(8'd1, 1'b1, 1'b1);
        send_beat(8'd0, 1'b0, 1'b0);
        send_beat(8'd255, 1'b1, 1'b0);
        settle();

        // Largest limits with a long silence: the timers saturate and an interval
        // whose limit is the top value expires exactly at saturation.
        program_limits(STYLE_MAX, 1'b0);
        run_phase(300, 3, 280);
        settle();

        for (int p = 0; p < 10; p++) begin
            program_limits(styles[p], p[0]);
            run_phase(110, rates[$urandom_range(0, 3)], 0);
            settle();
        end

        // Wait on before the verdict in case anything stray follows from the output register.
        repeat (8) @(posedge i_clk);
        if (fails == 0 && words_pending == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
